// File: rtl/ifbs_pkg.sv
// shared constants, types and helpers of the information frame byte stuffer
package ifbs_pkg;

   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE  = 8'h7D;
   localparam logic [7:0] ESC_FLAG  = 8'h5E;
   localparam logic [7:0] ESC_ESC   = 8'h5D;
   localparam logic [7:0] CTRL_SEQ1 = 8'h40;
   localparam logic [7:0] CTRL_SEQ0 = 8'h00;

   localparam logic [7:0] ADDRESS_RESET = 8'h03;
   localparam logic [9:0] MAX_PAYLOAD_RESET = 10'd494;
   localparam logic [9:0] LEN_MAX = 10'd1023;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDRESS     = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PAYLOAD = 1'b1;
   localparam int CSR_DATA_W = 10;

   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   localparam int OUT_DEPTH = 2;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   typedef struct packed {
      logic       hdr;
      logic [7:0] addr;
      logic [7:0] ctrl;
      logic [7:0] hchk;
      logic [7:0] data;
      logic       close;
      logic [7:0] chk;
   } cmd_type;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       frame_end;
      logic       run_last;
   } out_type;

   typedef enum logic [3:0] {
      STEP_FIRST,
      STEP_HFLAG,
      STEP_ADDR,
      STEP_CTRL,
      STEP_HCHK,
      STEP_DATA,
      STEP_DATA_ESC,
      STEP_CHK,
      STEP_CHK_ESC,
      STEP_FLAG
   } step_type;

   function automatic logic is_special(input logic [7:0] b);
      return (b == FLAG_BYTE) || (b == ESC_BYTE);
   endfunction

   function automatic logic [7:0] esc_code(input logic [7:0] b);
      return (b == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
   endfunction

endpackage

// File: rtl/ifbs_front.sv
// front part: configuration, frame state and classification of each payload byte
module ifbs_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [ifbs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ifbs_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               push,
   input  logic                               full,
   input  logic [7:0]                         data_byte,
   input  logic                               end_of_data,
   input  logic                               sequence_bit,
   output logic                               cmd_push,
   output ifbs_pkg::cmd_type                  cmd
);

   logic [7:0] address_ff;
   logic [9:0] max_payload_ff;
   logic       open_ff, open_in;
   logic [7:0] acc_ff, acc_in;
   logic [9:0] len_ff, len_in;

   logic [7:0]  ctrl;
   logic [7:0]  acc_new;
   logic [9:0]  len_base;
   logic [10:0] len_sum;
   logic [9:0]  len_new;
   logic        close;

   always_comb begin
      ctrl     = sequence_bit ? ifbs_pkg::CTRL_SEQ1 : ifbs_pkg::CTRL_SEQ0;
      acc_new  = (open_ff ? acc_ff : 8'h00) ^ data_byte;
      len_base = open_ff ? len_ff : 10'd0;
      len_sum  = {1'b0, len_base} + (ifbs_pkg::is_special(data_byte) ? 11'd2 : 11'd1);
      len_new  = len_sum[10] ? ifbs_pkg::LEN_MAX : len_sum[9:0];
      close    = end_of_data || (len_new >= max_payload_ff);
      cmd_push = push && !full;

      cmd.hdr   = !open_ff;
      cmd.addr  = address_ff;
      cmd.ctrl  = ctrl;
      cmd.hchk  = address_ff ^ ctrl;
      cmd.data  = data_byte;
      cmd.close = close;
      cmd.chk   = acc_new;

      open_in = open_ff;
      acc_in  = acc_ff;
      len_in  = len_ff;
      if (cmd_push) begin
         open_in = !close;
         acc_in  = close ? 8'h00 : acc_new;
         len_in  = close ? 10'd0 : len_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff     <= ifbs_pkg::ADDRESS_RESET;
         max_payload_ff <= ifbs_pkg::MAX_PAYLOAD_RESET;
         open_ff        <= 1'b0;
         acc_ff         <= 8'h00;
         len_ff         <= 10'd0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               ifbs_pkg::CSR_ADDRESS:     address_ff     <= csr_wdata[7:0];
               ifbs_pkg::CSR_MAX_PAYLOAD: max_payload_ff <= csr_wdata[9:0];
               default: ;
            endcase
         end
         open_ff <= open_in;
         acc_ff  <= acc_in;
         len_ff  <= len_in;
      end
   end

endmodule

// File: rtl/ifbs_cmd_queue.sv
// short command queue between the front and back parts
module ifbs_cmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  ifbs_pkg::cmd_type  wr_cmd,
   input  logic               rd_en,
   output logic               full,
   output logic               empty,
   output ifbs_pkg::cmd_type  rd_cmd
);

   ifbs_pkg::cmd_type entry_ff [ifbs_pkg::CMD_DEPTH];
   logic [ifbs_pkg::CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ifbs_pkg::CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ifbs_pkg::CMD_CNT_W-1:0] count_ff, count_in;
   logic do_wr, do_rd;

   always_comb begin
      full      = (count_ff == ifbs_pkg::CMD_CNT_W'(ifbs_pkg::CMD_DEPTH));
      empty     = (count_ff == '0);
      do_wr     = wr_en && !full;
      do_rd     = rd_en && !empty;
      rd_cmd    = entry_ff[rd_ptr_ff];
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/ifbs_back.sv
// back part: expands each command into line bytes and buffers the results
module ifbs_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_empty,
   input  ifbs_pkg::cmd_type  cmd,
   output logic               cmd_pop,
   input  logic               pop,
   output logic               empty,
   output logic [7:0]         line_byte,
   output logic               frame_end,
   output logic               run_last
);

   ifbs_pkg::step_type step_ff, step_in, cur_step;
   ifbs_pkg::out_type  out_entry_ff [ifbs_pkg::OUT_DEPTH];
   ifbs_pkg::out_type  gen;
   logic [ifbs_pkg::OUT_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ifbs_pkg::OUT_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ifbs_pkg::OUT_CNT_W-1:0] count_ff, count_in;
   logic out_full, fire, do_rd, data_esc, chk_esc;

   always_comb begin
      data_esc = ifbs_pkg::is_special(cmd.data);
      chk_esc  = ifbs_pkg::is_special(cmd.chk);
      out_full = (count_ff == ifbs_pkg::OUT_CNT_W'(ifbs_pkg::OUT_DEPTH));
      fire     = !cmd_empty && !out_full;
      if (step_ff == ifbs_pkg::STEP_FIRST) begin
         cur_step = cmd.hdr ? ifbs_pkg::STEP_HFLAG : ifbs_pkg::STEP_DATA;
      end else begin
         cur_step = step_ff;
      end
   end

   // byte for the current step
   always_comb begin
      gen.frame_end = 1'b0;
      gen.run_last  = 1'b0;
      unique case (cur_step)
         ifbs_pkg::STEP_HFLAG: gen.line_byte = ifbs_pkg::FLAG_BYTE;
         ifbs_pkg::STEP_ADDR:  gen.line_byte = cmd.addr;
         ifbs_pkg::STEP_CTRL:  gen.line_byte = cmd.ctrl;
         ifbs_pkg::STEP_HCHK:  gen.line_byte = cmd.hchk;
         ifbs_pkg::STEP_DATA: begin
            gen.line_byte = data_esc ? ifbs_pkg::ESC_BYTE : cmd.data;
            gen.run_last  = !data_esc && !cmd.close;
         end
         ifbs_pkg::STEP_DATA_ESC: begin
            gen.line_byte = ifbs_pkg::esc_code(cmd.data);
            gen.run_last  = !cmd.close;
         end
         ifbs_pkg::STEP_CHK:     gen.line_byte = chk_esc ? ifbs_pkg::ESC_BYTE : cmd.chk;
         ifbs_pkg::STEP_CHK_ESC: gen.line_byte = ifbs_pkg::esc_code(cmd.chk);
         ifbs_pkg::STEP_FLAG: begin
            gen.line_byte = ifbs_pkg::FLAG_BYTE;
            gen.frame_end = 1'b1;
            gen.run_last  = 1'b1;
         end
         default: gen.line_byte = ifbs_pkg::FLAG_BYTE;
      endcase
      cmd_pop = fire && gen.run_last;
   end

   // next step
   always_comb begin
      step_in = step_ff;
      if (fire) begin
         if (gen.run_last) begin
            step_in = ifbs_pkg::STEP_FIRST;
         end else begin
            unique case (cur_step)
               ifbs_pkg::STEP_HFLAG:    step_in = ifbs_pkg::STEP_ADDR;
               ifbs_pkg::STEP_ADDR:     step_in = ifbs_pkg::STEP_CTRL;
               ifbs_pkg::STEP_CTRL:     step_in = ifbs_pkg::STEP_HCHK;
               ifbs_pkg::STEP_HCHK:     step_in = ifbs_pkg::STEP_DATA;
               ifbs_pkg::STEP_DATA:
                  step_in = data_esc ? ifbs_pkg::STEP_DATA_ESC : ifbs_pkg::STEP_CHK;
               ifbs_pkg::STEP_DATA_ESC: step_in = ifbs_pkg::STEP_CHK;
               ifbs_pkg::STEP_CHK:
                  step_in = chk_esc ? ifbs_pkg::STEP_CHK_ESC : ifbs_pkg::STEP_FLAG;
               ifbs_pkg::STEP_CHK_ESC:  step_in = ifbs_pkg::STEP_FLAG;
               default:                 step_in = ifbs_pkg::STEP_FIRST;
            endcase
         end
      end
   end

   // result buffer
   always_comb begin
      empty     = (count_ff == '0);
      do_rd     = pop && !empty;
      line_byte = out_entry_ff[rd_ptr_ff].line_byte;
      frame_end = out_entry_ff[rd_ptr_ff].frame_end;
      run_last  = out_entry_ff[rd_ptr_ff].run_last;
      wr_ptr_in = fire ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (fire && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_entry_ff[wr_ptr_ff] <= gen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= ifbs_pkg::STEP_FIRST;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         step_ff   <= step_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/info_frame_byte_stuffer_unit.sv
// top level of the information frame byte stuffer
//
//  channel   direction  handshake          payload
//  req       in         push / full        data_byte, end_of_data, sequence_bit
//  rsp       out        pop / empty        line_byte, frame_end, run_last
//  csr       in         csr_wr_en          csr_index, csr_wdata
//
// one line byte is made per cycle while a command waits and the result buffer has room;
// the back sequencer yields 1 to 9 line bytes per transaction, one per plain data byte
// and two per stuffed one. a request is taken whenever the four-entry command queue has
// room, even while results wait; results pass through the command queue and result buffer.
// reset is synchronous and clears the frame state, queues and sequencer.
module info_frame_byte_stuffer_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [ifbs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ifbs_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              push,
   output logic                              full,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_end_of_data,
   input  logic                              req_sequence_bit,
   output logic                              empty,
   input  logic                              pop,
   output logic [7:0]                        rsp_line_byte,
   output logic                              rsp_frame_end,
   output logic                              rsp_run_last
);

   ifbs_pkg::cmd_type wr_cmd, rd_cmd;
   logic cmd_push, cmd_pop, cmd_empty;

   ifbs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .push         (push),
      .full         (full),
      .data_byte    (req_data_byte),
      .end_of_data  (req_end_of_data),
      .sequence_bit (req_sequence_bit),
      .cmd_push     (cmd_push),
      .cmd          (wr_cmd)
   );

   ifbs_cmd_queue u_cmd_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (cmd_push),
      .wr_cmd (wr_cmd),
      .rd_en  (cmd_pop),
      .full   (full),
      .empty  (cmd_empty),
      .rd_cmd (rd_cmd)
   );

   ifbs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd       (rd_cmd),
      .cmd_pop   (cmd_pop),
      .pop       (pop),
      .empty     (empty),
      .line_byte (rsp_line_byte),
      .frame_end (rsp_frame_end),
      .run_last  (rsp_run_last)
   );

endmodule

// File: verif/ifbs_frame_checker.sv
// frame predictor and line byte scoreboard for the information frame byte stuffer
module ifbs_frame_checker
   import ifbs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   push,
   input  logic                   full,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_end_of_data,
   input  logic                   req_sequence_bit,
   input  logic                   empty,
   input  logic                   pop,
   input  logic [7:0]             rsp_line_byte,
   input  logic                   rsp_frame_end,
   input  logic                   rsp_run_last,
   output int                     fail_count,
   output int                     waiting_results,
   output int                     request_count,
   output int                     line_count,
   output int                     frame_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [7:0] address_shadow;
   logic [9:0] limit_shadow;
   logic       frame_open;
   logic [7:0] check_xor;
   logic [9:0] stuffed_len;
   out_type    line_q[$];

   function automatic void emit_line(input logic [7:0] b, input logic fend);
      out_type o;
      o.line_byte = b;
      o.frame_end = fend;
      o.run_last  = 1'b0;
      line_q.push_back(o);
   endfunction

   function automatic int emit_stuffed(input logic [7:0] b);
      if (b == FLAG_BYTE) begin
         emit_line(ESC_BYTE, 1'b0);
         emit_line(ESC_FLAG, 1'b0);
         return 2;
      end
      if (b == ESC_BYTE) begin
         emit_line(ESC_BYTE, 1'b0);
         emit_line(ESC_ESC, 1'b0);
         return 2;
      end
      emit_line(b, 1'b0);
      return 1;
   endfunction

   function automatic void predict_frame_bytes(input logic [7:0] d, input logic eod,
                                               input logic seq);
      logic [7:0] ctrl;
      int         len;
      out_type    tail;
      // header bytes go out raw
      if (!frame_open) begin
         ctrl = seq ? CTRL_SEQ1 : CTRL_SEQ0;
         emit_line(FLAG_BYTE, 1'b0);
         emit_line(address_shadow, 1'b0);
         emit_line(ctrl, 1'b0);
         emit_line(address_shadow ^ ctrl, 1'b0);
         frame_open  = 1'b1;
         check_xor   = 8'h00;
         stuffed_len = 10'd0;
      end
      check_xor = check_xor ^ d;
      len = int'(stuffed_len) + emit_stuffed(d);
      if (len > int'(LEN_MAX))
         len = int'(LEN_MAX);
      stuffed_len = len[9:0];
      if (eod || stuffed_len >= limit_shadow) begin
         void'(emit_stuffed(check_xor));
         emit_line(FLAG_BYTE, 1'b1);
         frame_open  = 1'b0;
         check_xor   = 8'h00;
         stuffed_len = 10'd0;
      end
      tail = line_q.pop_back();
      tail.run_last = 1'b1;
      line_q.push_back(tail);
   endfunction

   function automatic void report(input string field, input int want, input int got);
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
   endfunction

   always @(posedge clock) begin : monitor
      out_type want;
      if (reset) begin
         address_shadow = ADDRESS_RESET;
         limit_shadow   = MAX_PAYLOAD_RESET;
         frame_open     = 1'b0;
         check_xor      = 8'h00;
         stuffed_len    = 10'd0;
         line_q.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_ADDRESS)
               address_shadow = csr_wdata[7:0];
            else if (csr_index == CSR_MAX_PAYLOAD)
               limit_shadow = csr_wdata;
         end
         if (push && !full) begin
            request_count++;
            predict_frame_bytes(req_data_byte, req_end_of_data, req_sequence_bit);
         end
         if (pop && !empty) begin
            line_count++;
            if (rsp_frame_end === 1'b1)
               frame_count++;
            if (line_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected transaction, expected none, actual byte %0h",
                        $time, rsp_line_byte);
            end else begin
               want = line_q.pop_front();
               if (rsp_line_byte !== want.line_byte)
                  report("line_byte", int'(want.line_byte), int'(rsp_line_byte));
               if (rsp_frame_end !== want.frame_end)
                  report("frame_end", int'(want.frame_end), int'(rsp_frame_end));
               if (rsp_run_last !== want.run_last)
                  report("run_last", int'(want.run_last), int'(rsp_run_last));
            end
         end
      end
      waiting_results = line_q.size();
   end

endmodule

// File: verif/tb_info_frame_byte_stuffer_unit.sv
// testbench top: stimulus, line side flow control and verdict for the byte stuffer
module tb_info_frame_byte_stuffer_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import ifbs_pkg::*;

   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 40;
   localparam int LONG_FRAME   = 60;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   csr_wr_en        = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = CSR_ADDRESS;
   logic [CSR_DATA_W-1:0]  csr_wdata        = '0;
   logic                   push             = 1'b0;
   logic                   full;
   logic [7:0]             req_data_byte    = 8'h00;
   logic                   req_end_of_data  = 1'b0;
   logic                   req_sequence_bit = 1'b0;
   logic                   empty;
   logic                   pop              = 1'b0;
   logic [7:0]             rsp_line_byte;
   logic                   rsp_frame_end;
   logic                   rsp_run_last;

   int fail_count;
   int waiting_results;
   int request_count;
   int line_count;
   int frame_count;
   int settings_count = 0;
   bit sender_quiet   = 1'b0;
   bit hold_req       = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   info_frame_byte_stuffer_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .push             (push),
      .full             (full),
      .req_data_byte    (req_data_byte),
      .req_end_of_data  (req_end_of_data),
      .req_sequence_bit (req_sequence_bit),
      .empty            (empty),
      .pop              (pop),
      .rsp_line_byte    (rsp_line_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_run_last     (rsp_run_last)
   );

   ifbs_frame_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .push             (push),
      .full             (full),
      .req_data_byte    (req_data_byte),
      .req_end_of_data  (req_end_of_data),
      .req_sequence_bit (req_sequence_bit),
      .empty            (empty),
      .pop              (pop),
      .rsp_line_byte    (rsp_line_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_run_last     (rsp_run_last),
      .fail_count       (fail_count),
      .waiting_results  (waiting_results),
      .request_count    (request_count),
      .line_count       (line_count),
      .frame_count      (frame_count)
   );

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] d, input logic eod, input logic seq);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      push             <= 1'b1;
      req_data_byte    <= d;
      req_end_of_data  <= eod;
      req_sequence_bit <= seq;
      do @(posedge clock); while (full);
      @(negedge clock);
   endtask

   task automatic drain();
      push <= 1'b0;
      while (waiting_results != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [9:0] val);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      settings_count++;
   endtask

   task automatic send_random_byte();
      logic [7:0] d;
      case ($urandom_range(0, 7))
         0, 1:    d = FLAG_BYTE;
         2:       d = ESC_BYTE;
         default: d = 8'($urandom_range(0, 255));
      endcase
      send_byte(d, $urandom_range(0, 5) == 0, 1'($urandom_range(0, 1)));
   endtask

   // line side: random pops, quiet bursts and one long hold-off on request
   initial begin : line_sink
      int gap;
      int quiet_left;
      quiet_left = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_req) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end
         if (quiet_left > 0) begin
            quiet_left--;
            gap = 0;
         end else begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 49) == 0)
               quiet_left = 60;
         end
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      logic [7:0] addr;
      logic [9:0] limit;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: single and multi byte frames, stuffed data and stuffed check bytes
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'hFF, 1'b1, 1'b1);
      send_byte(FLAG_BYTE, 1'b1, 1'b0);
      send_byte(ESC_BYTE, 1'b1, 1'b1);
      send_byte(FLAG_BYTE, 1'b0, 1'b1);
      send_byte(8'h12, 1'b0, 1'b0);
      send_byte(ESC_BYTE, 1'b1, 1'b1);
      send_byte(8'h01, 1'b0, 1'b0);
      send_byte(8'h7C, 1'b1, 1'b0);
      send_byte(8'h7F, 1'b0, 1'b1);
      send_byte(8'h01, 1'b1, 1'b1);

      // length limit at the bottom of its range
      write_reg(CSR_ADDRESS, 10'h0FF);
      write_reg(CSR_MAX_PAYLOAD, 10'd2);
      send_byte(8'h41, 1'b0, 1'b1);
      send_byte(8'h42, 1'b0, 1'b0);
      send_byte(FLAG_BYTE, 1'b0, 1'b0);

      // limit below range closes after every byte
      write_reg(CSR_ADDRESS, 10'h000);
      write_reg(CSR_MAX_PAYLOAD, 10'd1);
      send_byte(8'h55, 1'b0, 1'b0);
      send_byte(ESC_BYTE, 1'b0, 1'b1);
      write_reg(CSR_MAX_PAYLOAD, 10'd0);
      send_byte(8'hAA, 1'b0, 1'b1);
      send_byte(8'h80, 1'b0, 1'b0);

      // address and header check equal to flag or escape stay raw
      write_reg(CSR_MAX_PAYLOAD, 10'd3);
      write_reg(CSR_ADDRESS, {2'b00, FLAG_BYTE});
      send_byte(8'h11, 1'b1, 1'b0);
      write_reg(CSR_ADDRESS, 10'h03D);
      send_byte(8'h22, 1'b1, 1'b1);

      for (int p = 0; p < 6; p++) begin
         addr = (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : 8'($urandom_range(0, 255));
         case (p)
            0:       limit = 10'($urandom_range(2, 24));
            1:       limit = 10'd2;
            2:       limit = 10'($urandom_range(2, 60));
            3:       limit = LEN_MAX;
            4:       limit = 10'd3;
            default: limit = 10'($urandom_range(2, 200));
         endcase
         write_reg(CSR_ADDRESS, {2'b00, addr});
         write_reg(CSR_MAX_PAYLOAD, limit);
         sender_quiet = (p == 1) || (p == 4);
         if (p == 2)
            hold_req = 1'b1;
         repeat (PHASE_ITEMS) send_random_byte();
      end

      // one long frame of escaped bytes under the largest limit
      write_reg(CSR_ADDRESS, 10'h05A);
      write_reg(CSR_MAX_PAYLOAD, LEN_MAX);
      sender_quiet = 1'b1;
      repeat (LONG_FRAME)
         send_byte($urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE, 1'b0,
                   1'($urandom_range(0, 1)));
      sender_quiet = 1'b0;
      send_byte(8'h00, 1'b1, 1'b1);

      drain();
      repeat (10) @(negedge clock);
      $display("covered %0d data bytes and %0d line bytes in %0d frames", request_count,
               line_count, frame_count);
      $display("across %0d register writes, with stalls on both sides and one long hold-off",
               settings_count);
      if (fail_count == 0)
         $display("info_frame_byte_stuffer_unit test passed");
      else
         $display("info_frame_byte_stuffer_unit test failed");
      $finish;
   end

   initial begin : watchdog
      #5ms;
      $display("info_frame_byte_stuffer_unit test failed");
      $finish;
   end

endmodule

// File: files.f
rtl/ifbs_pkg.sv
rtl/ifbs_front.sv
rtl/ifbs_cmd_queue.sv
rtl/ifbs_back.sv
rtl/info_frame_byte_stuffer_unit.sv
verif/ifbs_frame_checker.sv
verif/tb_info_frame_byte_stuffer_unit.sv
